[hdl/pci_intx_gsi_level_aggregator_macros.svh]
// ----------------------------------------------------------------------------
// pci_intx_gsi_level_aggregator assertion macros
// Shared concurrent assertion forms for the aggregator checkers.
// ----------------------------------------------------------------------------
`ifndef PCI_INTX_GSI_LEVEL_AGGREGATOR_MACROS_SVH
`define PCI_INTX_GSI_LEVEL_AGGREGATOR_MACROS_SVH

// property checked only while out of reset
`define INTX_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// property checked on every edge, reset included
`define INTX_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

[hdl/intx_pkg.sv]
// ----------------------------------------------------------------------------
// intx_pkg
// Types, constants and the pin to line mapping of the INTx aggregator.
// ----------------------------------------------------------------------------
package intx_pkg;

  localparam int LINE_COUNT    = 32;
  localparam int PINS_PER_LINE = 4;

  typedef logic [4:0] dev_t;
  typedef logic [1:0] pin_t;
  typedef logic [4:0] line_idx_t;
  typedef logic [5:0] line_num_t;
  typedef logic [PINS_PER_LINE-1:0] line_pins_t;

  localparam line_num_t LINE_BASE = 6'd16;

  // request command codes
  localparam logic CMD_ASSERT   = 1'b0;
  localparam logic CMD_DEASSERT = 1'b1;

  // line table outcome for one request
  typedef struct packed {
    logic fire;
    logic level;
  } line_evt_t;

  // ((dev << 2) + (dev >> 3) + pin) mod 32
  function automatic line_idx_t line_index(dev_t dev, pin_t pin);
    line_idx_t sum;
    sum = {dev[2:0], 2'b00} + {3'b000, dev[4:3]} + {3'b000, pin};
    return sum;
  endfunction

  // global line number for a line index
  function automatic line_num_t line_number(line_idx_t idx);
    line_num_t num;
    num = {1'b0, idx} + LINE_BASE;
    return num;
  endfunction

endpackage

[hdl/intx_if.sv]
// ----------------------------------------------------------------------------
// intx_if
// Valid/ready channels for pin requests and line level changes.
// ----------------------------------------------------------------------------
interface intx_req_if;
  logic                valid;
  logic                ready;
  logic                cmd;
  intx_pkg::dev_t      device_number;
  intx_pkg::pin_t      pin;

  modport source (output valid, cmd, device_number, pin, input ready);
  modport sink   (input valid, cmd, device_number, pin, output ready);
endinterface

interface intx_lvl_if;
  logic                valid;
  logic                ready;
  intx_pkg::line_num_t line_number;
  logic                level;

  modport source (output valid, line_number, level, input ready);
  modport sink   (input valid, line_number, level, output ready);
endinterface

[hdl/pci_intx_gsi_level_aggregator.sv]
// ----------------------------------------------------------------------------
// pci_intx_gsi_level_aggregator
// Folds PCI INTx pin events into level changes of shared global lines.
// ----------------------------------------------------------------------------
// Usage:
//   in_req  : pin requests (cmd 0 asserts, 1 deasserts; device_number, pin).
//   out_lvl : level changes (line_number 16..47, level 1 raised, 0 lowered).
//   A request that does not change its pin, or that leaves its line's
//   asserted-pin count away from the 0/1 boundary, produces no output.
// Path: an accepted request passes the input register, then the result
//   register, before any level change it causes shows on out_lvl.
// Throughput: one request per cycle while out_lvl is not stalled; the line
//   bitmap is flops, updated by a single read-modify-write as the result loads.
// Reset: synchronous, active low; all pins and lines clear, both channels
//   empty, in_req.ready high in the first cycle after reset.
// Stall: while a level change waits on out_lvl, one more request may sit in
//   the input register; further requests are held off by in_req.ready low.
module pci_intx_gsi_level_aggregator (
  input  logic            clk,
  input  logic            rst_n,
  intx_req_if.sink        in_req,
  intx_lvl_if.source      out_lvl
);

  logic                 in_valid_r;
  logic                 cmd_r;
  intx_pkg::dev_t       dev_r;
  intx_pkg::pin_t       pin_r;
  logic                 out_valid_r;
  intx_pkg::line_num_t  line_num_r;
  logic                 level_r;
  logic                 advance;
  logic                 upd_en;
  intx_pkg::line_idx_t  line_idx;
  intx_pkg::line_evt_t  evt;

  // handshake control
  assign advance       = !out_valid_r || out_lvl.ready;
  assign upd_en        = in_valid_r && advance;
  assign in_req.ready  = !in_valid_r || advance;
  assign line_idx      = intx_pkg::line_index(dev_r, pin_r);

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_req.ready) begin
      in_valid_r <= in_req.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_req.ready && in_req.valid) begin
      cmd_r <= in_req.cmd;
      dev_r <= in_req.device_number;
      pin_r <= in_req.pin;
    end
  end

  intx_line_table u_table (
    .clk      (clk),
    .rst_n    (rst_n),
    .upd_en   (upd_en),
    .cmd      (cmd_r),
    .line_idx (line_idx),
    .pin      (pin_r),
    .evt      (evt)
  );

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (upd_en) begin
      out_valid_r <= evt.fire;
    end else if (out_lvl.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (upd_en && evt.fire) begin
      line_num_r <= intx_pkg::line_number(line_idx);
      level_r    <= evt.level;
    end
  end

  assign out_lvl.valid       = out_valid_r;
  assign out_lvl.line_number = line_num_r;
  assign out_lvl.level       = level_r;

endmodule

[hdl/intx_line_table.sv]
// ----------------------------------------------------------------------------
// intx_line_table
// Per line pin bitmap; the asserted pin count is the bitmap's population.
// ----------------------------------------------------------------------------
// For a fixed pin the mapping is one to one over devices, so each line has
// exactly one slot per pin code and the pin code picks the bit in the row.
module intx_line_table (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 upd_en,
  input  logic                 cmd,
  input  intx_pkg::line_idx_t  line_idx,
  input  intx_pkg::pin_t       pin,
  output intx_pkg::line_evt_t  evt
);

  intx_pkg::line_pins_t pins_r [intx_pkg::LINE_COUNT];
  intx_pkg::line_pins_t row_cur;
  intx_pkg::line_pins_t row_nxt;
  intx_pkg::line_pins_t pin_sel;

  // read-modify-write of one row
  always_comb begin
    row_cur   = pins_r[line_idx];
    pin_sel   = intx_pkg::line_pins_t'(1) << pin;
    row_nxt   = row_cur;
    evt.fire  = 1'b0;
    evt.level = 1'b0;
    if (cmd == intx_pkg::CMD_ASSERT) begin
      if ((row_cur & pin_sel) == '0) begin
        row_nxt   = row_cur | pin_sel;
        evt.fire  = (row_cur == '0);
        evt.level = 1'b1;
      end
    end else begin
      if ((row_cur & pin_sel) != '0) begin
        row_nxt   = row_cur & ~pin_sel;
        evt.fire  = (row_nxt == '0);
        evt.level = 1'b0;
      end
    end
  end

  // bitmap storage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < intx_pkg::LINE_COUNT; i++) begin
        pins_r[i] <= '0;
      end
    end else if (upd_en) begin
      pins_r[line_idx] <= row_nxt;
    end
  end

endmodule

[hdl/intx_checker.sv]
// ----------------------------------------------------------------------------
// intx_checker
// Port-level checks of the INTx aggregator, bound to the top level.
// ----------------------------------------------------------------------------
`include "pci_intx_gsi_level_aggregator_macros.svh"

module intx_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                in_valid,
  input logic                in_ready,
  input logic                out_valid,
  input logic                out_ready,
  input intx_pkg::line_num_t line_number,
  input logic                level
);

  // a waiting level change is not dropped
  `INTX_ASSERT(a_out_hold, clk, rst_n, out_valid && !out_ready |=> out_valid && $stable(line_number) && $stable(level), "output dropped or changed while stalled")

  // line numbers stay in the global range
  `INTX_ASSERT(a_line_range, clk, rst_n, out_valid |-> line_number >= 6'd16 && line_number <= 6'd47, "line number out of range")

  // reset empties the output and opens the input
  `INTX_ASSERT_ALWAYS(a_reset_clear, clk, !rst_n |=> !out_valid && in_ready, "channels not clear after reset")

  // with the output drained the input never blocks
  `INTX_ASSERT(a_no_block, clk, rst_n, !out_valid |-> in_ready, "input blocked with empty output")

  // the input blocks only behind a stalled output
  `INTX_ASSERT(a_progress, clk, rst_n, !in_ready |-> out_valid && !out_ready, "input blocked without back pressure")

endmodule

bind pci_intx_gsi_level_aggregator intx_checker u_intx_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .in_valid    (in_req.valid),
  .in_ready    (in_req.ready),
  .out_valid   (out_lvl.valid),
  .out_ready   (out_lvl.ready),
  .line_number (out_lvl.line_number),
  .level       (out_lvl.level)
);

[test/tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the INTx line aggregator: a table of directed
// requests, then random assert/deassert traffic with gaps and back-pressure,
// every level change checked against a bench-side pin and line tracker.
// ----------------------------------------------------------------------------
module tb;

  localparam int  CLK_HALF    = 5;
  localparam int  RST_CYCLES  = 8;
  localparam int  RAND_REQS   = 1250;
  localparam int  DRAIN_WAIT  = 8;
  localparam int  CYCLE_LIMIT = 400000;
  localparam int  DIR_ROWS    = 21;
  localparam int  PIN_TOTAL   = 128;
  localparam logic LVL_LOWERED = 1'b0;
  localparam logic LVL_RAISED  = 1'b1;
  localparam logic CMD_A       = intx_pkg::CMD_ASSERT;
  localparam logic CMD_D       = intx_pkg::CMD_DEASSERT;

  // one request, with an optional hand-written outcome
  typedef struct packed {
    logic                cmd;
    intx_pkg::dev_t      dev;
    intx_pkg::pin_t      pin;
    logic                typed;
    logic                fires;
    intx_pkg::line_num_t line;
    logic                level;
  } req_row_t;

  typedef struct packed {
    intx_pkg::line_num_t line;
    logic                level;
  } lvl_chg_t;

  logic clk;
  logic rst_n;

  intx_req_if req_ch ();
  intx_lvl_if lvl_ch ();

  pci_intx_gsi_level_aggregator uut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_req  (req_ch),
    .out_lvl (lvl_ch)
  );

  // bench copy of pin bits and per-line counts
  logic       pin_on    [PIN_TOTAL];
  logic [2:0] line_hits [intx_pkg::LINE_COUNT];

  lvl_chg_t pending_levels [$];
  req_row_t dir_tab [DIR_ROWS];

  int  err_count   = 0;
  int  cycle_count = 0;
  int  stall_hold  = 0;
  bit  calm        = 0;

  // clock
  initial clk = 1'b0;
  always #CLK_HALF clk = ~clk;

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  task automatic report_mismatch(input string what);
    $display("mismatch at cycle %0d: %s", cycle_count, what);
    err_count++;
  endtask

  // fold one pin event into the tracker, returns 1 when the line level moves
  function automatic bit fold_pin_event(input logic cmd, input intx_pkg::dev_t dev,
                                        input intx_pkg::pin_t pin, output lvl_chg_t chg);
    int idx;
    int bitpos;
    idx    = (int'(dev) * 4 + int'(dev) / 8 + int'(pin)) % intx_pkg::LINE_COUNT;
    bitpos = int'(dev) * 4 + int'(pin);
    chg.line = intx_pkg::line_num_t'(idx + 16);
    if (cmd == CMD_A) begin
      if (pin_on[bitpos]) return 1'b0;
      pin_on[bitpos] = 1'b1;
      line_hits[idx] = line_hits[idx] + 3'd1;
      chg.level = LVL_RAISED;
      return line_hits[idx] == 3'd1;
    end
    if (!pin_on[bitpos]) return 1'b0;
    pin_on[bitpos] = 1'b0;
    line_hits[idx] = line_hits[idx] - 3'd1;
    chg.level = LVL_LOWERED;
    return line_hits[idx] == 3'd0;
  endfunction

  // mostly short gaps, a few long, none in calm stretches
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // drive one request, wait for acceptance, record its level change
  task automatic apply_request(input req_row_t row);
    int       gap;
    bit       fires;
    lvl_chg_t chg;
    gap = pick_gap();
    if (gap > 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_ch.valid         <= 1'b1;
    req_ch.cmd           <= row.cmd;
    req_ch.device_number <= row.dev;
    req_ch.pin           <= row.pin;
    do @(posedge clk); while (!req_ch.ready);
    fires = fold_pin_event(row.cmd, row.dev, row.pin, chg);
    if (row.typed) begin
      fires     = row.fires;
      chg.line  = row.line;
      chg.level = row.level;
    end
    if (fires) pending_levels.push_back(chg);
  endtask

  task automatic check_level(input intx_pkg::line_num_t line, input logic level);
    lvl_chg_t want;
    if (pending_levels.size() == 0) begin
      report_mismatch($sformatf("unexpected level change line %0d level %0b", line, level));
      return;
    end
    want = pending_levels.pop_front();
    if (line !== want.line)
      report_mismatch($sformatf("line_number %0d, expected %0d", line, want.line));
    if (level !== want.level)
      report_mismatch($sformatf("level %0b on line %0d, expected %0b", level, want.line,
                                want.level));
  endtask

  // result side: check accepted level changes, back-pressure at random
  always @(posedge clk) begin
    if (rst_n && lvl_ch.valid && lvl_ch.ready) check_level(lvl_ch.line_number, lvl_ch.level);
    if (calm) begin
      lvl_ch.ready <= 1'b1;
      stall_hold   <= 0;
    end else if (stall_hold != 0) begin
      stall_hold <= stall_hold - 1;
    end else begin
      lvl_ch.ready <= ($urandom_range(0, 99) < 65);
      stall_hold   <= ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40)
                                                  : $urandom_range(0, 3);
    end
  end

  // stimulus
  initial begin
    req_row_t row;
    req_row_t last_row;
    bit       assert_heavy;
    int       r;

    rst_n                = 1'b0;
    req_ch.valid         = 1'b0;
    req_ch.cmd           = CMD_A;
    req_ch.device_number = '0;
    req_ch.pin           = '0;
    lvl_ch.ready         = 1'b0;
    for (int i = 0; i < PIN_TOTAL; i++) pin_on[i] = 1'b0;
    for (int i = 0; i < intx_pkg::LINE_COUNT; i++) line_hits[i] = 3'd0;

    // directed rows: typed outcome where obvious, tracker otherwise
    dir_tab = '{
      // first assert after reset raises line 16, repeat is ignored
      '{CMD_A, 5'd0,  2'd0, 1'b1, 1'b1, 6'd16, LVL_RAISED},
      '{CMD_A, 5'd0,  2'd0, 1'b1, 1'b0, 6'd0,  LVL_LOWERED},
      '{CMD_D, 5'd0,  2'd0, 1'b1, 1'b1, 6'd16, LVL_LOWERED},
      '{CMD_D, 5'd0,  2'd0, 1'b1, 1'b0, 6'd0,  LVL_LOWERED},
      // top device and pin, deassert of a clear pin first
      '{CMD_D, 5'd31, 2'd3, 1'b1, 1'b0, 6'd0,  LVL_LOWERED},
      '{CMD_A, 5'd31, 2'd3, 1'b1, 1'b1, 6'd18, LVL_RAISED},
      '{CMD_D, 5'd31, 2'd3, 1'b1, 1'b1, 6'd18, LVL_LOWERED},
      // all four pins sharing line 16, up to a full count and back down
      '{CMD_A, 5'd0,  2'd0, 1'b0, 1'b0, 6'd0,  LVL_LOWERED},
      '{CMD_A, 5'd15, 2'd3, 1'b0, 1'b0, 6'd0,  LVL_LOWERED},
      '{CMD_A, 5'd23, 2'd2, 1'b0, 1'b0, 6'd0,  LVL_LOWERED},
      '{CMD_A, 5'd31, 2'd1, 1'b0, 1'b0, 6'd0,  LVL_LOWERED},
      '{CMD_A, 5'd15, 2'd3, 1'b0, 1'b0, 6'd0,  LVL_LOWERED},
      '{CMD_D, 5'd0,  2'd0, 1'b0, 1'b0, 6'd0,  LVL_LOWERED},
      '{CMD_D, 5'd23, 2'd2, 1'b0, 1'b0, 6'd0,  LVL_LOWERED},
      '{CMD_D, 5'd31, 2'd1, 1'b0, 1'b0, 6'd0,  LVL_LOWERED},
      '{CMD_D, 5'd15, 2'd3, 1'b0, 1'b0, 6'd0,  LVL_LOWERED},
      '{CMD_D, 5'd15, 2'd3, 1'b0, 1'b0, 6'd0,  LVL_LOWERED},
      // more device extremes
      '{CMD_A, 5'd31, 2'd0, 1'b0, 1'b0, 6'd0,  LVL_LOWERED},
      '{CMD_A, 5'd16, 2'd2, 1'b0, 1'b0, 6'd0,  LVL_LOWERED},
      '{CMD_D, 5'd31, 2'd0, 1'b0, 1'b0, 6'd0,  LVL_LOWERED},
      '{CMD_D, 5'd16, 2'd2, 1'b0, 1'b0, 6'd0,  LVL_LOWERED}
    };

    repeat (RST_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int i = 0; i < DIR_ROWS; i++) apply_request(dir_tab[i]);

    // random traffic in assert-heavy and deassert-heavy phases
    last_row       = dir_tab[0];
    last_row.typed = 1'b0;
    assert_heavy   = 1'b1;
    for (int i = 0; i < RAND_REQS; i++) begin
      calm = ((i / 150) % 4) == 3;
      if (i % 60 == 0) assert_heavy = $urandom_range(0, 1);
      r = $urandom_range(0, 99);
      if (r < 6) begin
        row = last_row;
      end else begin
        row.cmd   = (r % 4 == 0) ? (assert_heavy ? CMD_D : CMD_A)
                                 : (assert_heavy ? CMD_A : CMD_D);
        row.dev   = intx_pkg::dev_t'($urandom_range(0, 31));
        row.pin   = intx_pkg::pin_t'($urandom_range(0, 3));
        row.typed = 1'b0;
        row.fires = 1'b0;
        row.line  = '0;
        row.level = LVL_LOWERED;
      end
      last_row = row;
      apply_request(row);
    end
    req_ch.valid <= 1'b0;
    calm = 1'b0;

    // drain, then allow for any stray level change
    while (pending_levels.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
    if (err_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

[pci_intx_gsi_level_aggregator.f]
+incdir+hdl
hdl/intx_pkg.sv
hdl/intx_if.sv
hdl/intx_line_table.sv
hdl/pci_intx_gsi_level_aggregator.sv
hdl/intx_checker.sv
test/tb.sv
